@@ sv/radio_command_receiver_top_macros.svh @@
// Assertion helpers for the receiver RTL.
`ifndef RADIO_COMMAND_RECEIVER_TOP_MACROS_SVH
`define RADIO_COMMAND_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rcr_pkg.sv @@
`timescale 1ns / 1ps

package rcr_pkg;

  // Log geometry
  localparam int LOG_SLOTS = 512;
  localparam logic [9:0] LIST_LIMIT = 10'(LOG_SLOTS - 3);
  localparam logic [8:0] SLOT_WAKE = 9'((LOG_SLOTS - 3) % 512);
  localparam logic [8:0] SLOT_TIME = 9'((LOG_SLOTS - 2) % 512);
  localparam logic [8:0] SLOT_SEND = 9'((LOG_SLOTS - 1) % 512);

  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd3000;
  localparam logic [15:0] IDLE_MAX = 16'hffff;

  // Register map (word index)
  localparam logic REG_NODE_ADDR    = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic [7:0] {
    TYPE_WAKE      = 8'h01,
    TYPE_TIME_CAL  = 8'h3e,
    TYPE_LIST_ST   = 8'h13,
    TYPE_LIST_DATA = 8'h25,
    TYPE_LIST_END  = 8'h57,
    TYPE_SEND      = 8'h42,
    TYPE_RESEND    = 8'hb3,
    TYPE_SLEEP     = 8'h85
  } pkt_type_t;

  typedef enum logic [2:0] {
    RSP_NONE    = 3'd0,
    RSP_WAKE    = 3'd1,
    RSP_TIME    = 3'd2,
    RSP_IDS_OK  = 3'd3,
    RSP_IDS_RST = 3'd4,
    RSP_SEND    = 3'd5,
    RSP_RESEND  = 3'd6,
    RSP_SLEEP   = 3'd7
  } rsp_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pkt_type;
    logic [7:0] pkt_address;
    logic [7:0] len_high;
    logic [7:0] len_low;
    logic [7:0] count_add;
  } rcr_item_t;

  typedef struct packed {
    rsp_t       response;
    logic       set_clock;
    logic       log_valid;
    logic [8:0] log_slot;
  } rcr_result_t;

  typedef struct packed {
    logic [15:0] band_length;
    logic [15:0] id_total;
    logic [9:0]  list_packets;
    logic [15:0] idle_count;
  } rcr_state_t;

endpackage

@@ sv/radio_command_receiver_top.sv @@
`timescale 1ns / 1ps

// Radio command receiver: takes one beat per cycle, either a received packet
// (in_kind 0) or a one-millisecond tick (in_kind 1), and returns exactly one
// result beat for each. A beat goes into an input register, is decoded against
// the node state in one pass of short logic, and lands in a result register,
// so a new beat is taken every cycle as long as the result side keeps up;
// with out_ready low an empty input register still takes one more beat
// before in_ready drops. Packets for other addresses and unknown
// types give a result with response 0. The idle counter advances on ticks,
// saturates, and requests sleep (response 7) once it is strictly greater than
// idle_timeout_ms; any nonzero response clears it. Registers: node_address at
// byte address 0, idle_timeout_ms at byte address 4 (reset 3000); write them
// only while no beat is in flight.
module radio_command_receiver_top import rcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_pkt_type,
  input  logic [7:0]  in_pkt_address,
  input  logic [7:0]  in_len_high,
  input  logic [7:0]  in_len_low,
  input  logic [7:0]  in_count_add,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_response,
  output logic        out_set_clock,
  output logic        out_log_valid,
  output logic [8:0]  out_log_slot,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "radio_command_receiver_top_macros.svh"

  // Configuration registers
  logic [7:0]  node_address_r;
  logic [15:0] idle_timeout_r;
  logic        cfg_wr;

  // Pipeline stages
  logic        a_valid_r;
  rcr_item_t   a_item_r;
  logic        a_advance;
  logic        out_valid_r;
  rcr_result_t out_result_r;

  // Node state
  rcr_state_t  state_r;
  rcr_state_t  state_nxt;
  rcr_result_t result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r <= 8'd0;
      idle_timeout_r <= IDLE_TIMEOUT_RESET;
    end else if (cfg_wr) begin
      // Low address bits select a byte lane and are ignored
      if (paddr[2] == REG_NODE_ADDR) begin
        node_address_r <= pwdata[7:0];
      end else begin
        idle_timeout_r <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_IDLE_TIMEOUT) begin
      prdata = {16'd0, idle_timeout_r};
    end else begin
      prdata = {24'd0, node_address_r};
    end
  end

  // Advance the decoded beat when the result register is empty or draining
  assign a_advance = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !a_valid_r || a_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item_r <= '{kind: in_kind, pkt_type: in_pkt_type, pkt_address: in_pkt_address,
                    len_high: in_len_high, len_low: in_len_low, count_add: in_count_add};
    end
  end

  rcr_decode u_decode (
    .item            (a_item_r),
    .state           (state_r),
    .node_address    (node_address_r),
    .idle_timeout_ms (idle_timeout_r),
    .result          (result),
    .state_nxt       (state_nxt)
  );

  // Commit state only when the beat moves on, so a stall never double-counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (a_advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      out_result_r <= result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_response  = out_result_r.response;
  assign out_set_clock = out_result_r.set_clock;
  assign out_log_valid = out_result_r.log_valid;
  assign out_log_slot  = out_result_r.log_slot;

  `RCR_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, a_valid_r, "accepted beat not held in input stage")
  `RCR_ASSERT_NOW(a_slot_clear, out_valid_r && !out_result_r.log_valid, out_result_r.log_slot == 9'd0, "log slot set without log")
  `RCR_ASSERT_NOW(a_clock_time, out_valid_r && out_result_r.set_clock, out_result_r.response == RSP_TIME, "clock set outside time ack")
  `RCR_ASSERT_NEXT(a_idle_clear, a_advance && result.response != RSP_NONE, state_r.idle_count == 16'd0, "idle count not cleared on response")

endmodule

@@ sv/rcr_decode.sv @@
`timescale 1ns / 1ps

module rcr_decode import rcr_pkg::*; (
  input  rcr_item_t   item,
  input  rcr_state_t  state,
  input  logic [7:0]  node_address,
  input  logic [15:0] idle_timeout_ms,
  output rcr_result_t result,
  output rcr_state_t  state_nxt
);

  logic [15:0] idle_inc;

  always_comb begin
    idle_inc  = (state.idle_count == IDLE_MAX) ? IDLE_MAX : state.idle_count + 16'd1;
    result    = '{response: RSP_NONE, set_clock: 1'b0, log_valid: 1'b0, log_slot: 9'd0};
    state_nxt = state;

    if (item.kind == KIND_TICK) begin
      state_nxt.idle_count = idle_inc;
      if (idle_inc > idle_timeout_ms) begin
        result.response = RSP_SLEEP;
      end
    end else if (item.pkt_address == node_address) begin
      unique case (item.pkt_type)
        TYPE_WAKE: begin
          result.response  = RSP_WAKE;
          result.log_valid = 1'b1;
          result.log_slot  = SLOT_WAKE;
        end
        TYPE_TIME_CAL: begin
          result.response  = RSP_TIME;
          result.set_clock = 1'b1;
          result.log_valid = 1'b1;
          result.log_slot  = SLOT_TIME;
        end
        TYPE_LIST_ST: begin
          state_nxt.band_length  = {item.len_high, item.len_low};
          state_nxt.id_total     = 16'd0;
          state_nxt.list_packets = 10'd0;
        end
        TYPE_LIST_DATA: begin
          // Stop advancing once the list area of the log is full
          if (state.list_packets < LIST_LIMIT) begin
            result.log_valid       = 1'b1;
            result.log_slot        = state.list_packets[8:0];
            state_nxt.list_packets = state.list_packets + 10'd1;
          end
          state_nxt.id_total = state.id_total + {8'd0, item.count_add};
        end
        TYPE_LIST_END: begin
          result.response = (state.id_total == state.band_length) ? RSP_IDS_OK : RSP_IDS_RST;
        end
        TYPE_SEND: begin
          result.response  = RSP_SEND;
          result.log_valid = 1'b1;
          result.log_slot  = SLOT_SEND;
        end
        TYPE_RESEND: result.response = RSP_RESEND;
        TYPE_SLEEP:  result.response = RSP_SLEEP;
        default: ;
      endcase
    end

    if (result.response != RSP_NONE) begin
      state_nxt.idle_count = 16'd0;
    end
  end

endmodule

@@ verif/tb_radio_command_receiver_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the radio command receiver: a driver and a monitor
// in clocked always blocks, a model of the node state that decodes every
// accepted beat into the result it should produce, and an initial block that
// queues the stimulus phase by phase and writes the registers in between.
module tb_radio_command_receiver_top;
  import rcr_pkg::*;

  // Clock, reset and every block input start at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_PACKET;
  logic [7:0]  in_pkt_type = '0;
  logic [7:0]  in_pkt_address = '0;
  logic [7:0]  in_len_high = '0;
  logic [7:0]  in_len_low = '0;
  logic [7:0]  in_count_add = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_response;
  logic        out_set_clock;
  logic        out_log_valid;
  logic [8:0]  out_log_slot;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  radio_command_receiver_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_pkt_type    (in_pkt_type),
    .in_pkt_address (in_pkt_address),
    .in_len_high    (in_len_high),
    .in_len_low     (in_len_low),
    .in_count_add   (in_count_add),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_response   (out_response),
    .out_set_clock  (out_set_clock),
    .out_log_valid  (out_log_valid),
    .out_log_slot   (out_log_slot),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial forever #1 clk = ~clk;

  // Beats still to be offered, and the results owed for beats already taken.
  rcr_item_t   pending_beats[$];
  rcr_result_t awaited_results[$];

  // Idle chances in percent, set per phase by the stimulus block.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Scoreboard counters.
  int err_count = 0;
  int beats_checked = 0;
  int sleeps_seen = 0;
  int ids_ok_seen = 0;
  int logged_seen = 0;

  // Node state as the block should hold it, plus its copy of the registers.
  logic [7:0]  node_addr = 8'd0;
  logic [15:0] timeout_ms = IDLE_TIMEOUT_RESET;
  logic [15:0] band_len = '0;
  logic [15:0] id_sum = '0;
  logic [9:0]  list_cnt = '0;
  logic [15:0] idle_ms = '0;

  // Decode one accepted beat against the node state and advance that state.
  function automatic rcr_result_t decode_beat(input rcr_item_t b);
    rcr_result_t r;
    r = '0;
    r.response = RSP_NONE;
    if (b.kind == KIND_TICK) begin
      // Count the millisecond, saturate, and ask for sleep past the timeout.
      if (idle_ms != IDLE_MAX) idle_ms = idle_ms + 16'd1;
      if (idle_ms > timeout_ms) r.response = RSP_SLEEP;
    end else if (b.pkt_address == node_addr) begin
      case (b.pkt_type)
        TYPE_WAKE: begin
          r.response = RSP_WAKE;
          r.log_valid = 1'b1;
          r.log_slot = SLOT_WAKE;
        end
        TYPE_TIME_CAL: begin
          r.response = RSP_TIME;
          r.set_clock = 1'b1;
          r.log_valid = 1'b1;
          r.log_slot = SLOT_TIME;
        end
        TYPE_LIST_ST: begin
          // Load the band length and restart the list.
          band_len = {b.len_high, b.len_low};
          id_sum = '0;
          list_cnt = '0;
        end
        TYPE_LIST_DATA: begin
          // Drop the log entry once the list area is full; still count ids.
          if (list_cnt < LIST_LIMIT) begin
            r.log_valid = 1'b1;
            r.log_slot = list_cnt[8:0];
            list_cnt = list_cnt + 10'd1;
          end
          id_sum = id_sum + {8'h00, b.count_add};
        end
        TYPE_LIST_END: begin
          r.response = (id_sum == band_len) ? RSP_IDS_OK : RSP_IDS_RST;
        end
        TYPE_SEND: begin
          r.response = RSP_SEND;
          r.log_valid = 1'b1;
          r.log_slot = SLOT_SEND;
        end
        TYPE_RESEND: r.response = RSP_RESEND;
        TYPE_SLEEP:  r.response = RSP_SLEEP;
        default: ;
      endcase
    end
    // Any response restarts the idle time.
    if (r.response != RSP_NONE) idle_ms = '0;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (err_count < 40)
      $display("%0t ns: beat %0d %s: got %0h, want %0h",
               $time, beats_checked, what, got, want);
    err_count++;
  endtask

  // Driver: record the accepted beat, then hold, offer the next one, or idle.
  always @(posedge clk) begin : feed
    rcr_item_t taken;
    rcr_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.kind = in_kind;
        taken.pkt_type = in_pkt_type;
        taken.pkt_address = in_pkt_address;
        taken.len_high = in_len_high;
        taken.len_low = in_len_low;
        taken.count_add = in_count_add;
        awaited_results.push_back(decode_beat(taken));
      end
      if (in_valid && !in_ready) begin
        // Hold the beat until the block takes it.
      end else if (pending_beats.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_kind <= nxt.kind;
        in_pkt_type <= nxt.pkt_type;
        in_pkt_address <= nxt.pkt_address;
        in_len_high <= nxt.len_high;
        in_len_low <= nxt.len_low;
        in_count_add <= nxt.count_add;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off after the first hundred
  // results so the block fills up and drops in_ready while beats keep coming.
  int  hold_left = 0;
  int  seen_beats = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) seen_beats <= seen_beats + 1;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && seen_beats >= 100) begin
        hold_done <= 1'b1;
        hold_left <= 80;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: compare each result beat with the oldest one owed.
  always @(posedge clk) begin : watch
    rcr_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected beat, response", out_response, RSP_NONE);
      end else begin
        want = awaited_results.pop_front();
        if (out_response !== want.response)
          flag_mismatch("response", out_response, want.response);
        if (out_set_clock !== want.set_clock)
          flag_mismatch("set_clock", out_set_clock, want.set_clock);
        if (out_log_valid !== want.log_valid)
          flag_mismatch("log_valid", out_log_valid, want.log_valid);
        if (out_log_slot !== want.log_slot)
          flag_mismatch("log_slot", out_log_slot, want.log_slot);
        if (want.response == RSP_SLEEP) sleeps_seen++;
        if (want.response == RSP_IDS_OK) ids_ok_seen++;
        if (want.log_valid) logged_seen++;
      end
      beats_checked++;
    end
  end

  // One random byte.
  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic void queue_beat(input logic kind, input logic [7:0] ty,
                                     input logic [7:0] ad, input logic [7:0] lh,
                                     input logic [7:0] ll, input logic [7:0] ca);
    rcr_item_t b;
    b.kind = kind;
    b.pkt_type = ty;
    b.pkt_address = ad;
    b.len_high = lh;
    b.len_low = ll;
    b.count_add = ca;
    pending_beats.push_back(b);
  endfunction

  // Ticks carry junk in the packet fields; the block must ignore it.
  function automatic void queue_tick();
    queue_beat(KIND_TICK, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
  endfunction

  function automatic logic [7:0] any_known_type();
    case ($urandom_range(0, 7))
      0: return TYPE_WAKE;
      1: return TYPE_TIME_CAL;
      2: return TYPE_LIST_ST;
      3: return TYPE_LIST_DATA;
      4: return TYPE_LIST_END;
      5: return TYPE_SEND;
      6: return TYPE_RESEND;
      default: return TYPE_SLEEP;
    endcase
  endfunction

  // Register write: setup cycle, access cycle, then release the bus.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_NODE_ADDR) node_addr = val[7:0];
    else timeout_ms = val;
    @(negedge clk);
  endtask

  // Pause the sender until every queued beat is taken and answered.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random mix: mostly well-formed list transfers and addressed commands,
  // with ticks, foreign addresses, unknown types and raw noise between.
  task automatic gen_random(input int n);
    int made;
    int k;
    int pick;
    logic [15:0] sum;
    logic [15:0] band;
    logic [7:0] cnts[$];
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // List transfer: half the time the band matches the id count.
        k = $urandom_range(1, 12);
        sum = '0;
        cnts.delete();
        repeat (k) begin
          cnts.push_back(rnd8());
          sum = sum + {8'h00, cnts[cnts.size() - 1]};
        end
        band = $urandom_range(0, 1) ? sum : 16'($urandom);
        queue_beat(KIND_PACKET, TYPE_LIST_ST, node_addr, band[15:8], band[7:0],
                   rnd8());
        foreach (cnts[i])
          queue_beat(KIND_PACKET, TYPE_LIST_DATA, node_addr, rnd8(), rnd8(),
                     cnts[i]);
        queue_beat(KIND_PACKET, TYPE_LIST_END, node_addr, rnd8(), rnd8(),
                   rnd8());
        made += k + 2;
      end else if (pick < 55) begin
        queue_beat(KIND_PACKET, any_known_type(), node_addr, rnd8(), rnd8(),
                   rnd8());
        made++;
      end else if (pick < 72) begin
        k = $urandom_range(1, 6);
        repeat (k) queue_tick();
        made += k;
      end else if (pick < 82) begin
        queue_beat(KIND_PACKET, any_known_type(),
                   node_addr ^ 8'($urandom_range(1, 255)), rnd8(), rnd8(),
                   rnd8());
        made++;
      end else if (pick < 92) begin
        queue_beat(KIND_PACKET, rnd8(), node_addr, rnd8(), rnd8(), rnd8());
        made++;
      end else begin
        queue_beat(1'($urandom), rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        made++;
      end
    end
  endtask

  // Random phase in two halves with a full drain between them.
  task automatic run_phase(input int sidle, input int rstall, input logic [7:0] na,
                           input logic [15:0] tmo, input int n);
    write_reg(REG_NODE_ADDR, {8'h00, na});
    write_reg(REG_IDLE_TIMEOUT, tmo);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    gen_random(n / 2);
    wait_drained();
    gen_random(n - n / 2);
    wait_drained();
  endtask

  initial begin
    // Hold reset, then release it once.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset register values: every type, list ok and resend,
    // unknown types, foreign address, ticks with all-ones and all-zeros junk.
    queue_beat(KIND_PACKET, TYPE_WAKE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_TIME_CAL, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_SEND, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_RESEND, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_SLEEP, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_ST, 8'h00, 8'h00, 8'h03, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_DATA, 8'h00, 8'h00, 8'h00, 8'h01);
    queue_beat(KIND_PACKET, TYPE_LIST_DATA, 8'h00, 8'h00, 8'h00, 8'h02);
    queue_beat(KIND_PACKET, TYPE_LIST_END, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_DATA, 8'h00, 8'hff, 8'hff, 8'hff);
    queue_beat(KIND_PACKET, TYPE_LIST_END, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff);
    queue_beat(KIND_PACKET, TYPE_WAKE, 8'hff, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_TICK, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_beat(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_ST, 8'h00, 8'hff, 8'hff, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_END, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Directed, extreme registers: zero timeout sleeps on every tick.
    write_reg(REG_NODE_ADDR, 16'h00ff);
    write_reg(REG_IDLE_TIMEOUT, 16'h0000);
    queue_tick();
    queue_tick();
    queue_beat(KIND_PACKET, TYPE_WAKE, 8'hff, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_WAKE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_DATA, 8'hff, 8'h00, 8'h00, 8'h80);
    queue_beat(KIND_PACKET, TYPE_LIST_END, 8'hff, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Fill the list area past its end so late list-data beats are dropped
    // from the log, then restart the list. No idling; the long receiver
    // hold-off lands in here.
    write_reg(REG_NODE_ADDR, 16'h005a);
    write_reg(REG_IDLE_TIMEOUT, 16'd2);
    queue_beat(KIND_PACKET, TYPE_LIST_ST, 8'h5a, 8'h12, 8'h34, 8'h00);
    repeat (512) queue_beat(KIND_PACKET, TYPE_LIST_DATA, 8'h5a, rnd8(), rnd8(),
                            rnd8());
    queue_beat(KIND_PACKET, TYPE_LIST_END, 8'h5a, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_ST, 8'h5a, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_DATA, 8'h5a, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_LIST_END, 8'h5a, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_PACKET, TYPE_WAKE, 8'h5a, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Random phases across the idling mixes and register settings.
    run_phase(0, 0, rnd8(), 16'd1, 70);
    run_phase(64, 0, 8'h00, 16'($urandom_range(0, 8)), 70);
    run_phase(0, 64, 8'hff, 16'd3, 70);
    run_phase(38, 38, rnd8(), 16'd0, 70);

    // Largest timeout: no tick may sleep. Then a zero timeout makes the
    // next tick sleep.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_IDLE_TIMEOUT, 16'hffff);
    repeat (12) queue_tick();
    wait_drained();
    write_reg(REG_IDLE_TIMEOUT, 16'h0000);
    queue_tick();
    queue_tick();
    queue_beat(KIND_PACKET, TYPE_TIME_CAL, node_addr, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Give a late or duplicated result time to show up.
    repeat (10) @(negedge clk);
    $display("summary: %0d result beats checked over directed, full-log, four idling",
             beats_checked);
    $display("  mixes and the largest timeout; %0d sleep, %0d ids complete, %0d logged",
             sleeps_seen, ids_ok_seen, logged_seen);
    if (err_count == 0) begin
      $display("tb_radio_command_receiver_top: clean");
    end else begin
      $display("tb_radio_command_receiver_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_radio_command_receiver_top: errors");
    $finish;
  end

endmodule
